FILE: src/fwa_pkg.sv
// Package with the shared constants and types of the forward window averager.
`timescale 1ns / 1ps

package fwa_pkg;

    // Boxcar length; results are window sums divided by this value.
    localparam int WINDOW = 10;

    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 16;
    localparam int LINE_D   = WINDOW - 1;
    localparam int FILL_W   = $clog2(WINDOW);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

    // Division by WINDOW is done as a multiply by a rounded-up reciprocal.
    // With the shift chosen as SUM_W + clog2(WINDOW) the error term stays
    // below one for every sum that fits in SUM_W bits.
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the sample on the input channel
        logic pop;      // emit one truncated-window result and drop the oldest sample
    } fwa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // output register is empty or is being emptied
        logic fill_one; // exactly one sample left in the line
    } fwa_status_t;

endpackage

FILE: src/fwa_stream_if.sv
// Stream interfaces for the sample input and the average output channels.
`timescale 1ns / 1ps

interface fwa_sample_if;
    import fwa_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                end_of_stream;

    modport source (output valid, output sample, output end_of_stream, input ready);
    modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface fwa_result_if;
    import fwa_pkg::*;

    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] average;
    logic             last_result;

    modport source (output valid, output average, output last_result, input ready);
    modport sink   (input valid, input average, input last_result, output ready);
endinterface

FILE: src/fwa_ctrl.sv
// Controller state machine: streaming phase and end-of-stream flush.
`timescale 1ns / 1ps

module fwa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 end_of_stream,
    output logic                 in_ready,
    input  fwa_pkg::fwa_status_t status,
    output fwa_pkg::fwa_cmd_t    cmd
);
    import fwa_pkg::*;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        in_ready   = (state_reg == ST_RUN) && status.out_free;
        cmd.accept = in_valid && in_ready;
        cmd.pop    = (state_reg == ST_FLUSH) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (cmd.accept && end_of_stream)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // The final pop empties the line and marks the last result.
                if (cmd.pop && status.fill_one)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/fwa_datapath.sv
// Datapath: sample line, running window sum, divide-by-window and output register.
`timescale 1ns / 1ps

module fwa_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fwa_pkg::fwa_cmd_t            cmd,
    input  logic [fwa_pkg::SAMPLE_W-1:0] sample,
    output fwa_pkg::fwa_status_t         status,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [fwa_pkg::AVG_W-1:0]    average,
    output logic                         last_result
);
    import fwa_pkg::*;

    logic [SAMPLE_W-1:0] line_reg [LINE_D];
    logic [SAMPLE_W-1:0] line_next [LINE_D];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [AVG_W-1:0]    avg_reg;
    logic                last_reg;

    logic [SUM_W-1:0]    total;
    logic [SUM_W-1:0]    emit_sum;
    logic [PROD_W-1:0]   prod;
    logic                full;
    logic                shift;
    logic                load;

    assign full  = (fill_reg == FILL_W'(LINE_D));
    assign total = sum_reg + SUM_W'(sample);
    assign shift = (cmd.accept && full) || cmd.pop;
    assign load  = shift;

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.fill_one = (fill_reg == FILL_W'(1));

    // A full window on an accepted sample includes the new sample; a flush
    // step uses the sum of what remains in the line.
    assign emit_sum = cmd.pop ? sum_reg : total;
    assign prod     = PROD_W'(emit_sum) * PROD_W'(RECIP);

    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        if (cmd.accept)
        begin
            if (full)
            begin
                sum_next = total - SUM_W'(line_reg[0]);
            end
            else
            begin
                sum_next  = total;
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            sum_next  = sum_reg - SUM_W'(line_reg[0]);
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < LINE_D - 1; i++)
        begin
            line_next[i] = line_reg[i];
            if (shift)
            begin
                line_next[i] = line_reg[i + 1];
            end
            else if (cmd.accept && (fill_reg == FILL_W'(i)))
            begin
                line_next[i] = sample;
            end
        end
        // Newest slot: filled in place or takes the sample as the line slides.
        line_next[LINE_D - 1] = line_reg[LINE_D - 1];
        if (cmd.accept && (full || (fill_reg == FILL_W'(LINE_D - 1))))
        begin
            line_next[LINE_D - 1] = sample;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
        if (load)
        begin
            avg_reg  <= prod[RECIP_SHIFT +: AVG_W];
            last_reg <= cmd.pop && status.fill_one;
        end
    end

    assign out_valid   = out_valid_reg;
    assign average     = avg_reg;
    assign last_result = last_reg;

endmodule

FILE: src/forward_window_average.sv
// Top level of the forward boxcar averager over a flagged sample stream.
`timescale 1ns / 1ps
// A full-window result is in the output register in the cycle after the transfer
// of the sample that completes the window; throughput is one sample per cycle
// while streaming and the output register is free. An end-of-stream sample starts
// a flush of up to WINDOW-1 further results, one per cycle while the output is
// free, taking no sample. Asynchronous reset clears fill, running sum, out valid.

module forward_window_average (
    input  logic         clk,
    input  logic         rst_n,
    fwa_sample_if.sink   sample_ch,
    fwa_result_if.source result_ch
);
    import fwa_pkg::*;

    // The controller decides when a sample transfer happens and when a flush
    // step runs; the datapath holds every stored value of the stream.
    fwa_cmd_t    cmd;
    fwa_status_t status;

    fwa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (sample_ch.valid),
        .end_of_stream (sample_ch.end_of_stream),
        .in_ready      (sample_ch.ready),
        .status        (status),
        .cmd           (cmd)
    );

    // The datapath keeps the last WINDOW-1 samples, their running sum and the
    // registered result. A result transfer on the output frees the register
    // in the same cycle, so the input keeps flowing when the sink is ready.
    fwa_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample      (sample_ch.sample),
        .status      (status),
        .out_ready   (result_ch.ready),
        .out_valid   (result_ch.valid),
        .average     (result_ch.average),
        .last_result (result_ch.last_result)
    );

endmodule

FILE: src/fwa_checker.sv
// Port-level checks of the forward window averager and their binding.
`timescale 1ns / 1ps

module fwa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         end_of_stream,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [fwa_pkg::AVG_W-1:0]    average,
    input logic                         last_result
);
    import fwa_pkg::*;

    // A stalled result holds its value until the transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(average)
                                       && $stable(last_result)))
        else $error("result changed while stalled");

    // Once the final sample is taken the flush runs before another sample.
    a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_of_stream) |=> !in_ready)
        else $error("sample taken at the start of a flush");

    // A sample is only taken when its result has somewhere to go.
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("input ready while output register is blocked");

endmodule

bind forward_window_average fwa_checker u_fwa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample_ch.valid),
    .in_ready      (sample_ch.ready),
    .end_of_stream (sample_ch.end_of_stream),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .average       (result_ch.average),
    .last_result   (result_ch.last_result)
);
